### sv/bsre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set-run extractor package
// Shared constants, the range record type and the lowest-set-bit search.
// ----------------------------------------------------------------------------
package bsre_pkg;

  localparam int DATA_W      = 64;
  localparam int WORD_BITS   = 64;
  localparam int MAX_WORDS   = 512;
  localparam int MAX_RESULTS = 32;
  localparam int BEGIN_W     = 15;
  localparam int END_W       = 16;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = $clog2(MAX_WORDS + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [DATA_W-1:0] WORD_MASK =
      (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

  typedef struct packed {
    logic [BEGIN_W-1:0] run_begin;
    logic [END_W-1:0]   run_end;
    logic               last_of_item;
  } bsre_range_t;

  // Position of the lowest set bit; zero when the vector is empty.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [DATA_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

### sv/bsre_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set-run extractor output buffer
// One-entry result register that decouples the scanner from the consumer.
// ----------------------------------------------------------------------------
module bsre_out_buf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  bsre_pkg::bsre_range_t        push_data,
  output logic                         push_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsre_pkg::BEGIN_W-1:0] run_begin,
  output logic [bsre_pkg::END_W-1:0]   run_end,
  output logic                         last_of_item
);
  import bsre_pkg::*;

  bsre_range_t held;

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      held <= push_data;
    end
  end

  assign run_begin    = held.run_begin;
  assign run_end      = held.run_end;
  assign last_of_item = held.last_of_item;

endmodule

### sv/bitmap_set_run_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set-run extractor
// Reports the maximal runs of set bits in a word stream as [begin, end), at most 32 per word.
// ----------------------------------------------------------------------------
// A word is taken while idle, then a shared lowest-set-bit search walks the
// word's transitions (bit differs from the bit below it), one transition per
// cycle, then finishes, with a closing range when the final word closes an
// open run. A word holds at most 64 transitions, so an alternating word is the
// slowest case; stalls on the result side hold the walk at a fall. in_ready is
// high only between words; a finished range may still wait in the output
// register while the next word is taken. Word positions stop counting at 512
// words; later words only close the bitmap.
module bitmap_set_run_extractor_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsre_pkg::DATA_W-1:0]  data_word,
  input  logic                         last_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsre_pkg::BEGIN_W-1:0] run_begin,
  output logic [bsre_pkg::END_W-1:0]   run_end,
  output logic                         last_of_item
);
  import bsre_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE
  } state_t;

  state_t             state;
  logic               run_open;
  logic [BEGIN_W-1:0] run_start;
  logic [IDX_W-1:0]   word_index;
  logic [DATA_W-1:0]  trans;
  logic [END_W-1:0]   base;
  logic               last_flag;
  logic               close_flag;
  logic               muted;
  logic [CNT_W-1:0]   cnt;

  logic               accept;
  logic               processed;
  logic [DATA_W-1:0]  masked;
  logic [BIT_W-1:0]   bit_idx;
  logic [END_W-1:0]   pos;
  logic [END_W-1:0]   close_pos;
  logic [DATA_W-1:0]  rem;
  logic               more_falls;
  logic               push;
  logic               push_ready;
  bsre_range_t        push_data;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign processed = (word_index < IDX_W'(MAX_WORDS));
  assign masked    = data_word & WORD_MASK;

  assign bit_idx    = lowest_set(trans);
  assign pos        = base + END_W'(bit_idx);
  assign rem        = trans & (trans - DATA_W'(1));
  // Remaining transitions start with a rise, so two or more hold another fall.
  assign more_falls = (rem & (rem - DATA_W'(1))) != '0;
  assign close_pos  = END_W'(32'(word_index) * WORD_BITS);

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    unique case (state)
      S_SCAN: begin
        if (trans != '0 && run_open && !muted) begin
          push                   = 1'b1;
          push_data.run_begin    = run_start;
          push_data.run_end      = pos;
          push_data.last_of_item = (cnt == CNT_W'(MAX_RESULTS - 1)) ||
                                   (!more_falls && !close_flag);
        end
      end
      S_CLOSE: begin
        push                   = 1'b1;
        push_data.run_begin    = run_start;
        push_data.run_end      = close_pos;
        push_data.last_of_item = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_open   <= 1'b0;
      run_start  <= '0;
      word_index <= '0;
      trans      <= '0;
      base       <= '0;
      last_flag  <= 1'b0;
      close_flag <= 1'b0;
      muted      <= 1'b0;
      cnt        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_flag <= last_word;
            cnt       <= '0;
            muted     <= 1'b0;
            base      <= END_W'(32'(word_index) * WORD_BITS);
            if (processed) begin
              trans      <= (masked ^ {masked[DATA_W-2:0], run_open}) & WORD_MASK;
              close_flag <= last_word && masked[WORD_BITS-1];
              word_index <= word_index + IDX_W'(1);
            end else begin
              trans      <= '0;
              close_flag <= last_word && run_open;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (trans == '0) begin
            if (close_flag && !muted) begin
              state <= S_CLOSE;
            end else begin
              state <= S_IDLE;
              if (last_flag) begin
                run_open   <= 1'b0;
                run_start  <= '0;
                word_index <= '0;
              end
            end
          end else if (!run_open) begin
            run_open  <= 1'b1;
            run_start <= pos[BEGIN_W-1:0];
            trans     <= rem;
          end else if (muted || push_ready) begin
            run_open <= 1'b0;
            trans    <= rem;
            if (!muted) begin
              cnt   <= cnt + CNT_W'(1);
              muted <= (cnt == CNT_W'(MAX_RESULTS - 1));
            end
          end
        end
        S_CLOSE: begin
          if (push_ready) begin
            state      <= S_IDLE;
            run_open   <= 1'b0;
            run_start  <= '0;
            word_index <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bsre_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .push_ready   (push_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_begin    (run_begin),
    .run_end      (run_end),
    .last_of_item (last_of_item)
  );

  // A range is only handed over when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
      (push && state == S_SCAN && !push_ready) |=> $stable(trans))
    else $error("scanner advanced past a stalled range");

  // Every range reported during the scan is non-empty.
  assert property (@(posedge clk) disable iff (rst)
      (push && state == S_SCAN) |-> ({1'b0, push_data.run_begin} < push_data.run_end))
    else $error("empty or inverted range");

  // The word counter never runs past its saturation point.
  assert property (@(posedge clk) disable iff (rst)
      word_index <= IDX_W'(MAX_WORDS))
    else $error("word index beyond saturation");

  // A final word leaves no run open behind it.
  assert property (@(posedge clk) disable iff (rst)
      ($past(state) != S_IDLE && state == S_IDLE && last_flag) |-> !run_open)
    else $error("run left open after final word");

  // A closing range is only issued while a run is open.
  assert property (@(posedge clk) disable iff (rst)
      (state == S_CLOSE) |-> run_open)
    else $error("closing range without an open run");

endmodule
